FILE: rtl/cda_pkg.sv
package cda_pkg;

  localparam int UpcW = 5;

  // Program labels
  localparam logic [UpcW-1:0] SWalkF = 5'd5;
  localparam logic [UpcW-1:0] SWalkB = 5'd6;
  localparam logic [UpcW-1:0] SDiff  = 5'd8;
  localparam logic [UpcW-1:0] SInv   = 5'd16;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_QUOT,
    OP_SPLIT,
    OP_ADDN,
    OP_WALKF,
    OP_WALKB,
    OP_DMUL,
    OP_DSUB,
    OP_DADD,
    OP_OUT_DATE,
    OP_OUT_DIFF,
    OP_OUT_INV
  } cda_op_e;

  typedef enum logic [2:0] {
    J_NONE,
    J_INVALID,
    J_DIFF,
    J_FWD,
    J_BACK
  } cda_cond_e;

  typedef enum logic {
    SRC_BASE,
    SRC_OTHER
  } cda_src_e;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_RANGE   = 2'd2
  } cda_status_e;

  typedef struct packed {
    cda_op_e         op;
    cda_src_e        src;
    cda_cond_e       cond;
    logic [UpcW-1:0] target;
    logic            last;
  } cda_ctrl_t;

  typedef struct packed {
    logic invalid;
    logic diff;
    logic fwd;
    logic back;
  } cda_flags_t;

  // Year kept as century and year-in-century, so no divide is needed here.
  function automatic logic is_leap(input logic [7:0] cent, input logic [6:0] yc);
    logic lp;
    if (yc != 7'd0) begin
      lp = (yc[1:0] == 2'd0);
    end else begin
      lp = (cent[1:0] == 2'd0);
    end
    return lp;
  endfunction

  function automatic logic [4:0] month_days(input logic leap, input logic [3:0] m);
    logic [4:0] n;
    case (m)
      4'd2: begin
        n = leap ? 5'd29 : 5'd28;
      end
      4'd4, 4'd6, 4'd9, 4'd11: begin
        n = 5'd30;
      end
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: begin
        n = 5'd31;
      end
      default: begin
        n = 5'd0;
      end
    endcase
    return n;
  endfunction

  // Days before month m in a March-based year: (153*mm+2)/5
  function automatic logic [8:0] month_offset(input logic [3:0] m);
    logic [8:0] n;
    case (m)
      4'd3:    n = 9'd0;
      4'd4:    n = 9'd31;
      4'd5:    n = 9'd61;
      4'd6:    n = 9'd92;
      4'd7:    n = 9'd122;
      4'd8:    n = 9'd153;
      4'd9:    n = 9'd184;
      4'd10:   n = 9'd214;
      4'd11:   n = 9'd245;
      4'd12:   n = 9'd275;
      4'd1:    n = 9'd306;
      4'd2:    n = 9'd337;
      default: n = 9'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/calendar_date_arithmetic_core.sv
// Gregorian date unit, microcoded. The add-days walk steps one month per cycle,
// forward or backward. One request in flight: the next can be taken in the
// done_o cycle; receiver cannot stall.
// Reset (rst_ni low, async) idles the sequencer and drops done_o; no pending result.
module calendar_date_arithmetic_core
  import cda_pkg::*;
#(
  parameter int MAX_OFFSET = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               action_i,
  input  logic [13:0]        base_year_i,
  input  logic [3:0]         base_month_i,
  input  logic [4:0]         base_day_i,
  input  logic [13:0]        other_year_i,
  input  logic [3:0]         other_month_i,
  input  logic [4:0]         other_day_i,
  input  logic signed [16:0] offset_days_i,
  output logic               done_o,
  output logic [13:0]        out_year_o,
  output logic [3:0]         out_month_o,
  output logic [4:0]         out_day_o,
  output logic signed [22:0] day_difference_o,
  output logic [1:0]         status_o
);

  // Request is taken when start is seen while idle; the inputs are latched in
  // the datapath at that edge, so they need not hold afterwards.
  logic            accept;
  logic            busy_w;
  logic [UpcW-1:0] upc;
  cda_ctrl_t       ctrl;
  cda_flags_t      flags;

  assign accept = start && !busy_w;
  assign busy   = busy_w;

  // Step counter with conditional jumps; the last control word ends the program.
  cda_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .ctrl_i   (ctrl),
    .flags_i  (flags),
    .busy_o   (busy_w),
    .upc_o    (upc)
  );

  // Program store: one control word per step.
  cda_ucode_rom u_rom (
    .upc_i  (upc),
    .ctrl_o (ctrl)
  );

  // Date registers, year split unit, day-number accumulator, result register.
  // Result fields are held until the next request completes; done_o pulses once.
  cda_datapath #(
    .MAX_OFFSET (MAX_OFFSET)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .load_i           (accept),
    .exec_i           (busy_w),
    .ctrl_i           (ctrl),
    .action_i         (action_i),
    .base_year_i      (base_year_i),
    .base_month_i     (base_month_i),
    .base_day_i       (base_day_i),
    .other_year_i     (other_year_i),
    .other_month_i    (other_month_i),
    .other_day_i      (other_day_i),
    .offset_days_i    (offset_days_i),
    .flags_o          (flags),
    .done_o           (done_o),
    .out_year_o       (out_year_o),
    .out_month_o      (out_month_o),
    .out_day_o        (out_day_o),
    .day_difference_o (day_difference_o),
    .status_o         (status_o)
  );

endmodule

FILE: rtl/cda_ucode_rom.sv
module cda_ucode_rom
  import cda_pkg::*;
(
  input  logic [UpcW-1:0] upc_i,
  output cda_ctrl_t       ctrl_o
);

  function automatic cda_ctrl_t cw(input cda_op_e op, input cda_src_e src,
                                   input cda_cond_e cond, input logic [UpcW-1:0] target,
                                   input logic last);
    cda_ctrl_t w;
    w.op     = op;
    w.src    = src;
    w.cond   = cond;
    w.target = target;
    w.last   = last;
    return w;
  endfunction

  always_comb begin
    case (upc_i)
      // split and check the first date
      5'd0:  ctrl_o = cw(OP_QUOT,     SRC_BASE,  J_NONE,    '0,     1'b0);
      5'd1:  ctrl_o = cw(OP_SPLIT,    SRC_BASE,  J_NONE,    '0,     1'b0);
      5'd2:  ctrl_o = cw(OP_NOP,      SRC_BASE,  J_INVALID, SInv,   1'b0);
      5'd3:  ctrl_o = cw(OP_NOP,      SRC_BASE,  J_DIFF,    SDiff,  1'b0);
      // add-days walk
      5'd4:  ctrl_o = cw(OP_ADDN,     SRC_BASE,  J_NONE,    '0,     1'b0);
      5'd5:  ctrl_o = cw(OP_WALKF,    SRC_BASE,  J_FWD,     SWalkF, 1'b0);
      5'd6:  ctrl_o = cw(OP_WALKB,    SRC_BASE,  J_BACK,    SWalkB, 1'b0);
      5'd7:  ctrl_o = cw(OP_OUT_DATE, SRC_BASE,  J_NONE,    '0,     1'b1);
      // days-until
      5'd8:  ctrl_o = cw(OP_DMUL,     SRC_BASE,  J_NONE,    '0,     1'b0);
      5'd9:  ctrl_o = cw(OP_DSUB,     SRC_BASE,  J_NONE,    '0,     1'b0);
      5'd10: ctrl_o = cw(OP_QUOT,     SRC_OTHER, J_NONE,    '0,     1'b0);
      5'd11: ctrl_o = cw(OP_SPLIT,    SRC_OTHER, J_NONE,    '0,     1'b0);
      5'd12: ctrl_o = cw(OP_NOP,      SRC_OTHER, J_INVALID, SInv,   1'b0);
      5'd13: ctrl_o = cw(OP_DMUL,     SRC_OTHER, J_NONE,    '0,     1'b0);
      5'd14: ctrl_o = cw(OP_DADD,     SRC_OTHER, J_NONE,    '0,     1'b0);
      5'd15: ctrl_o = cw(OP_OUT_DIFF, SRC_OTHER, J_NONE,    '0,     1'b1);
      5'd16: ctrl_o = cw(OP_OUT_INV,  SRC_BASE,  J_NONE,    '0,     1'b1);
      default: begin
        ctrl_o = cw(OP_OUT_INV, SRC_BASE, J_NONE, '0, 1'b1);
      end
    endcase
  end

endmodule

FILE: rtl/cda_sequencer.sv
module cda_sequencer
  import cda_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  cda_ctrl_t       ctrl_i,
  input  cda_flags_t      flags_i,
  output logic            busy_o,
  output logic [UpcW-1:0] upc_o
);

  logic            busy_q, busy_d;
  logic [UpcW-1:0] upc_q, upc_d;
  logic            take;

  always_comb begin
    case (ctrl_i.cond)
      J_NONE:    take = 1'b0;
      J_INVALID: take = flags_i.invalid;
      J_DIFF:    take = flags_i.diff;
      J_FWD:     take = flags_i.fwd;
      J_BACK:    take = flags_i.back;
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    upc_d  = upc_q;
    if (!busy_q) begin
      if (accept_i) begin
        busy_d = 1'b1;
        upc_d  = '0;
      end
    end else if (ctrl_i.last) begin
      busy_d = 1'b0;
      upc_d  = '0;
    end else if (take) begin
      upc_d = ctrl_i.target;
    end else begin
      upc_d = upc_q + UpcW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      upc_q  <= '0;
    end else begin
      busy_q <= busy_d;
      upc_q  <= upc_d;
    end
  end

  assign busy_o = busy_q;
  assign upc_o  = upc_q;

endmodule

FILE: rtl/cda_datapath.sv
module cda_datapath
  import cda_pkg::*;
#(
  parameter int MAX_OFFSET = 65535
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               exec_i,
  input  cda_ctrl_t          ctrl_i,
  input  logic               action_i,
  input  logic [13:0]        base_year_i,
  input  logic [3:0]         base_month_i,
  input  logic [4:0]         base_day_i,
  input  logic [13:0]        other_year_i,
  input  logic [3:0]         other_month_i,
  input  logic [4:0]         other_day_i,
  input  logic signed [16:0] offset_days_i,
  output cda_flags_t         flags_o,
  output logic               done_o,
  output logic [13:0]        out_year_o,
  output logic [3:0]         out_month_o,
  output logic [4:0]         out_day_o,
  output logic signed [22:0] day_difference_o,
  output logic [1:0]         status_o
);

  localparam logic signed [20:0] OffMax = 21'(MAX_OFFSET);
  localparam logic [23:0]        DnBias = 24'd1721119;

  // latched request
  logic               act_q;
  logic [13:0]        by_q, oy_q;
  logic [3:0]         bm_q, om_q;
  logic [4:0]         bd_q, od_q;
  logic signed [16:0] n_q;

  // working date and accumulator
  logic [7:0]         q_q, cent_q;
  logic [6:0]         yc_q;
  logic [13:0]        yr_q;
  logic [3:0]         m_q;
  logic signed [17:0] d_q;
  logic               ovf_q;
  logic [21:0]        p_q;
  logic signed [23:0] acc_q;

  // results
  logic               done_q;
  logic [13:0]        ry_q;
  logic [3:0]         rm_q;
  logic [4:0]         rd_q;
  logic signed [22:0] rdiff_q;
  cda_status_e        rst_q;

  logic signed [20:0] n_ext, n_sat;
  logic [13:0]        ysel;
  logic [3:0]         msel;
  logic [4:0]         dsel;
  logic [26:0]        quot_prod;
  logic [13:0]        rem_w;
  logic               cur_leap;
  logic [4:0]         cur_mdays;
  logic               fwd, back, invalid;
  logic [13:0]        yr_inc, yr_dec;
  logic [6:0]         yc_inc, yc_dec;
  logic [7:0]         cent_inc, cent_dec;
  logic [3:0]         m_b;
  logic [13:0]        yr_b;
  logic [6:0]         yc_b;
  logic [7:0]         cent_b;
  logic [4:0]         mdays_b;
  logic               a_jan;
  logic [13:0]        yp;
  logic [7:0]         centp;
  logic [23:0]        dn;

  // offset clamp to +/- MAX_OFFSET
  always_comb begin
    n_ext = 21'(offset_days_i);
    if (n_ext > OffMax) begin
      n_sat = OffMax;
    end else if (n_ext < -OffMax) begin
      n_sat = -OffMax;
    end else begin
      n_sat = n_ext;
    end
  end

  assign ysel = (ctrl_i.src == SRC_OTHER) ? oy_q : by_q;
  assign msel = (ctrl_i.src == SRC_OTHER) ? om_q : bm_q;
  assign dsel = (ctrl_i.src == SRC_OTHER) ? od_q : bd_q;

  // year / 100 by reciprocal 5243 / 2^19, exact for 14-bit years
  assign quot_prod = 27'(ysel) * 27'd5243;
  assign rem_w     = ysel - (14'(q_q) * 14'd100);

  assign cur_leap  = is_leap(cent_q, yc_q);
  assign cur_mdays = month_days(cur_leap, m_q);

  assign invalid = (yr_q == 14'd0) || (yr_q > 14'd9999) ||
                   (m_q == 4'd0) || (m_q > 4'd12) ||
                   (d_q < 18'sd1) || (d_q > $signed(18'(cur_mdays)));
  assign fwd  = !ovf_q && (d_q > $signed(18'(cur_mdays)));
  assign back = !ovf_q && (d_q < 18'sd1);

  assign flags_o.invalid = invalid;
  assign flags_o.diff    = act_q;
  assign flags_o.fwd     = fwd;
  assign flags_o.back    = back;

  // year carry / borrow in century form
  assign yr_inc   = yr_q + 14'd1;
  assign yr_dec   = yr_q - 14'd1;
  assign yc_inc   = (yc_q == 7'd99) ? 7'd0 : yc_q + 7'd1;
  assign cent_inc = (yc_q == 7'd99) ? cent_q + 8'd1 : cent_q;
  assign yc_dec   = (yc_q == 7'd0) ? 7'd99 : yc_q - 7'd1;
  assign cent_dec = (yc_q == 7'd0) ? cent_q - 8'd1 : cent_q;

  always_comb begin
    if (m_q == 4'd1) begin
      m_b    = 4'd12;
      yr_b   = yr_dec;
      yc_b   = yc_dec;
      cent_b = cent_dec;
    end else begin
      m_b    = m_q - 4'd1;
      yr_b   = yr_q;
      yc_b   = yc_q;
      cent_b = cent_q;
    end
    mdays_b = month_days(is_leap(cent_b, yc_b), m_b);
  end

  // day number pieces: Jan/Feb count as months of the previous year
  assign a_jan = (m_q == 4'd1) || (m_q == 4'd2);
  assign yp    = yr_q - 14'(a_jan);
  assign centp = cent_q - 8'(a_jan && (yc_q == 7'd0));
  assign dn    = 24'(d_q[4:0]) + 24'(month_offset(m_q)) + 24'(p_q) + 24'(yp >> 2)
               - 24'(centp) + 24'(centp >> 2) + DnBias;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      act_q <= action_i;
      by_q  <= base_year_i;
      bm_q  <= base_month_i;
      bd_q  <= base_day_i;
      oy_q  <= other_year_i;
      om_q  <= other_month_i;
      od_q  <= other_day_i;
      n_q   <= n_sat[16:0];
      ovf_q <= 1'b0;
    end else if (exec_i) begin
      case (ctrl_i.op)
        OP_QUOT: begin
          q_q <= quot_prod[26:19];
        end
        OP_SPLIT: begin
          cent_q <= q_q;
          yc_q   <= rem_w[6:0];
          yr_q   <= ysel;
          m_q    <= msel;
          d_q    <= 18'(dsel);
        end
        OP_ADDN: begin
          d_q <= d_q + 18'(n_q);
        end
        OP_WALKF: begin
          if (fwd) begin
            d_q <= d_q - $signed(18'(cur_mdays));
            if (m_q == 4'd12) begin
              m_q    <= 4'd1;
              yr_q   <= yr_inc;
              yc_q   <= yc_inc;
              cent_q <= cent_inc;
              ovf_q  <= (yr_inc > 14'd9999);
            end else begin
              m_q <= m_q + 4'd1;
            end
          end
        end
        OP_WALKB: begin
          if (back) begin
            m_q    <= m_b;
            yr_q   <= yr_b;
            yc_q   <= yc_b;
            cent_q <= cent_b;
            if (yr_b == 14'd0) begin
              ovf_q <= 1'b1;
            end else begin
              d_q <= d_q + $signed(18'(mdays_b));
            end
          end
        end
        OP_DMUL: begin
          p_q <= 22'(yp) * 22'd365;
        end
        OP_DSUB: begin
          acc_q <= -$signed(dn);
        end
        OP_DADD: begin
          acc_q <= acc_q + $signed(dn);
        end
        default: begin
        end
      endcase
    end
  end

  // result register, loaded by the closing step of each program
  always_ff @(posedge clk_i) begin
    if (exec_i && ctrl_i.last) begin
      case (ctrl_i.op)
        OP_OUT_DATE: begin
          rdiff_q <= '0;
          if (ovf_q) begin
            ry_q  <= '0;
            rm_q  <= '0;
            rd_q  <= '0;
            rst_q <= STATUS_RANGE;
          end else begin
            ry_q  <= yr_q;
            rm_q  <= m_q;
            rd_q  <= d_q[4:0];
            rst_q <= STATUS_OK;
          end
        end
        OP_OUT_DIFF: begin
          ry_q    <= '0;
          rm_q    <= '0;
          rd_q    <= '0;
          rdiff_q <= acc_q[22:0];
          rst_q   <= STATUS_OK;
        end
        default: begin
          ry_q    <= '0;
          rm_q    <= '0;
          rd_q    <= '0;
          rdiff_q <= '0;
          rst_q   <= STATUS_INVALID;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= exec_i && ctrl_i.last;
    end
  end

  assign done_o           = done_q;
  assign out_year_o       = ry_q;
  assign out_month_o      = rm_q;
  assign out_day_o        = rd_q;
  assign day_difference_o = rdiff_q;
  assign status_o         = rst_q;

endmodule
